// ===== rtl/bcp_pkg.sv =====
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared widths, constants, types and helpers of the byte to cell bit packer.
// ----------------------------------------------------------------------------
package bcp_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CellW    = 16;
    localparam int unsigned CfgW     = 5;
    localparam int unsigned AccW     = 24;
    localparam int unsigned HeldW    = 5;
    localparam int unsigned MaxCells = 8;
    localparam int unsigned CntW     = $clog2(MaxCells + 1);

    localparam logic [CfgW-1:0] CellWidthReset = CfgW'(8);
    localparam logic [CfgW-1:0] CellWidthMin   = CfgW'(1);
    localparam logic [CfgW-1:0] CellWidthMax   = CfgW'(CellW);

    typedef struct packed {
        logic [CellW-1:0] value;
        logic             last;
    } t_cell;

    // clamp the programmed width into 1..16
    function automatic logic [CfgW-1:0] eff_width(input logic [CfgW-1:0] w);
        logic [CfgW-1:0] r;
        if (w == '0) begin
            r = CellWidthMin;
        end else if (w > CellWidthMax) begin
            r = CellWidthMax;
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

// ===== rtl/bcp_if.sv =====
// ----------------------------------------------------------------------------
// bcp interfaces
// Valid/ready channels for bytes in, cells out and the width register write.
// ----------------------------------------------------------------------------
interface bcp_byte_if;
    logic                      valid;
    logic                      ready;
    logic [bcp_pkg::ByteW-1:0] data_byte;
    logic                      block_end;
    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface bcp_cell_if;
    logic                      valid;
    logic                      ready;
    logic [bcp_pkg::CellW-1:0] cell_value;
    logic                      cell_last;
    modport source (output valid, output cell_value, output cell_last, input ready);
    modport sink   (input valid, input cell_value, input cell_last, output ready);
endinterface

interface bcp_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [bcp_pkg::CfgW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bcp_accum.sv =====
// ----------------------------------------------------------------------------
// bcp_accum
// Bit accumulator: merges bytes, peels off one cell per cycle unless stalled.
// ----------------------------------------------------------------------------
module bcp_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bcp_pkg::CfgW-1:0]    i_width,
    bcp_byte_if.sink                    i_byte,
    output logic                        o_emit_valid,
    input  logic                        i_emit_ready,
    output bcp_pkg::t_cell              o_cell
);

    localparam logic [bcp_pkg::HeldW-1:0] CellWL  = bcp_pkg::HeldW'(bcp_pkg::CellW);
    localparam logic [bcp_pkg::HeldW-1:0] ByteWL  = bcp_pkg::HeldW'(bcp_pkg::ByteW);
    localparam logic [bcp_pkg::CntW-1:0]  MaxCntL = bcp_pkg::CntW'(bcp_pkg::MaxCells);

    logic [bcp_pkg::AccW-1:0]  r_acc,  n_acc;
    logic [bcp_pkg::HeldW-1:0] r_held, n_held;
    logic [bcp_pkg::CntW-1:0]  r_cnt,  n_cnt;
    logic                      r_end,  n_end;
    logic                      r_busy, n_busy;

    logic [bcp_pkg::HeldW-1:0] w;
    logic [bcp_pkg::HeldW-1:0] held_after;
    logic [bcp_pkg::CntW-1:0]  cnt_nx;
    logic [bcp_pkg::CellW-1:0] mask;
    logic                      full_ok, pad_ok, pending, more, fire, item_final, accept;
    logic [bcp_pkg::AccW-1:0]  acc_s;
    logic [bcp_pkg::HeldW-1:0] held_s;

    always_comb begin
        w          = bcp_pkg::HeldW'(i_width);
        held_after = r_held - w;
        cnt_nx     = r_cnt + bcp_pkg::CntW'(1);
        mask       = {bcp_pkg::CellW{1'b1}} >> (CellWL - w);

        full_ok = (r_held >= w) && (r_cnt < MaxCntL);
        pad_ok  = r_end && (r_held < w) && (r_held != '0) && (r_cnt < MaxCntL);
        pending = r_busy && (full_ok || pad_ok);
        // another cell of this transaction follows the current full cell
        more    = full_ok && (cnt_nx < MaxCntL) &&
                  ((held_after >= w) || (r_end && (held_after != '0)));

        fire       = pending && i_emit_ready;
        item_final = r_busy && (!pending || (fire && !more));

        i_byte.ready = !r_busy || item_final;
        accept       = i_byte.valid && i_byte.ready;

        o_emit_valid = pending;
        o_cell.value = r_acc[bcp_pkg::CellW-1:0] & mask;
        o_cell.last  = r_end && !more;

        acc_s  = r_acc;
        held_s = r_held;
        if (fire && full_ok) begin
            acc_s  = r_acc >> w;
            held_s = held_after;
        end
        // block end drops whatever is left
        if (item_final && r_end) begin
            acc_s  = '0;
            held_s = '0;
        end

        n_acc  = acc_s;
        n_held = held_s;
        n_cnt  = fire ? cnt_nx : r_cnt;
        n_end  = r_end;
        n_busy = r_busy && !item_final;
        if (accept) begin
            n_acc  = acc_s | (bcp_pkg::AccW'(i_byte.data_byte) << held_s[3:0]);
            n_held = held_s + ByteWL;
            n_cnt  = '0;
            n_end  = i_byte.block_end;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
            r_cnt  <= '0;
            r_end  <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_held <= n_held;
            r_cnt  <= n_cnt;
            r_end  <= n_end;
            r_busy <= n_busy;
        end
    end

endmodule

// ===== rtl/bcp_out_reg.sv =====
// ----------------------------------------------------------------------------
// bcp_out_reg
// Output register holding one cell until the receiver takes it.
// ----------------------------------------------------------------------------
module bcp_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bcp_pkg::t_cell i_cell,
    bcp_cell_if.source     o_cell
);

    logic           r_valid, n_valid;
    bcp_pkg::t_cell r_cell;

    always_comb begin
        o_ready = !r_valid || o_cell.ready;
        n_valid = i_valid || (r_valid && !o_cell.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cell <= i_cell;
        end
    end

    assign o_cell.valid      = r_valid;
    assign o_cell.cell_value = r_cell.value;
    assign o_cell.cell_last  = r_cell.last;

endmodule

// ===== rtl/byte_to_cell_bit_packer.sv =====
// ----------------------------------------------------------------------------
// byte_to_cell_bit_packer
// Repacks a byte stream, lsb first, into cells of 1 to 16 bits.
// ----------------------------------------------------------------------------
// i_byte: source bytes with block_end on the final byte of a block.
// o_cell: cells with cell_last on the final cell of a block; the final cell
//   carries leftover bits zero padded.
// i_cfg: one register, the cell width (0 acts as 1, above 16 acts as 16);
//   always ready, write it only while no transaction is in flight.
// A byte goes into the accumulator register, then one cell per cycle moves
// into the output register while it can take one; the first cell of a byte
// reaches o_cell through the accumulator and then the output register.
// The accumulator gives one cell per clock while the output register takes
// it, and takes the next byte only with the last cell of the current one:
// in steady use one byte per cycle for widths of 8 and above; a block end
// byte that flushes leftover bits gives two cells; width 1 gives up to 8.
// When the receiver stalls, the output register holds its cell, the
// accumulator keeps its cell pending and then stops taking bytes.
// Reset empties the accumulator, drops any held cell and sets the width to 8.
// ----------------------------------------------------------------------------
module byte_to_cell_bit_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcp_cfg_if.sink     i_cfg,
    bcp_byte_if.sink    i_byte,
    bcp_cell_if.source  o_cell
);

    logic [bcp_pkg::CfgW-1:0] r_cell_width;
    logic [bcp_pkg::CfgW-1:0] width_eff;
    logic                     emit_valid;
    logic                     emit_ready;
    bcp_pkg::t_cell           emit_cell;

    assign i_cfg.ready = 1'b1;
    assign width_eff   = bcp_pkg::eff_width(r_cell_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width <= bcp_pkg::CellWidthReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_cell_width <= i_cfg.data;
        end
    end

    bcp_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width      (width_eff),
        .i_byte       (i_byte),
        .o_emit_valid (emit_valid),
        .i_emit_ready (emit_ready),
        .o_cell       (emit_cell)
    );

    bcp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (emit_valid),
        .o_ready (emit_ready),
        .i_cell  (emit_cell),
        .o_cell  (o_cell)
    );

endmodule

// ===== tb/byte_to_cell_bit_packer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_to_cell_bit_packer_checker
// Watches the width, byte and cell channels. Keeps its own copy of the
// packer state and predicts the cells that each byte transaction releases.
// Compares every cell transaction, field by field, against the oldest
// predicted cell. Hands the error count and the number of cells still
// awaited to the test top.
// ----------------------------------------------------------------------------
module byte_to_cell_bit_packer_checker
    import bcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bcp_cfg_if   i_cfg,
    bcp_byte_if  i_byte,
    bcp_cell_if  i_cell,
    output int   o_errors,
    output int   o_pending
);

    logic [CfgW-1:0]  width_reg;
    logic [AccW-1:0]  acc_bits;
    logic [HeldW-1:0] held_count;
    t_cell            cells_due[$];
    int               error_count;

    // append one byte to the accumulator and queue the cells it releases
    task automatic pack_byte(input logic [ByteW-1:0] b, input logic blk_end);
        logic [CfgW-1:0]  w;
        logic [CellW-1:0] mask;
        t_cell            step_cells[MaxCells];
        int               n;
        w = (width_reg == '0) ? CfgW'(1) :
            (width_reg > CfgW'(CellW)) ? CfgW'(CellW) : width_reg;
        mask = CellW'((32'd1 << w) - 32'd1);
        n = 0;
        acc_bits   = acc_bits | (AccW'(b) << held_count[3:0]);
        held_count = {1'b0, held_count[3:0]} + HeldW'(ByteW);
        while (held_count >= w && n < MaxCells) begin
            step_cells[n].value = acc_bits[CellW-1:0] & mask;
            step_cells[n].last  = 1'b0;
            acc_bits   = acc_bits >> w;
            held_count = held_count - w;
            n++;
        end
        if (blk_end) begin
            // leftover bits go out zero padded, unless the step is already full
            if (held_count != '0 && n < MaxCells) begin
                step_cells[n].value = acc_bits[CellW-1:0] & mask;
                step_cells[n].last  = 1'b0;
                n++;
            end
            if (n > 0) begin
                step_cells[n-1].last = 1'b1;
            end
            acc_bits   = '0;
            held_count = '0;
        end
        for (int i = 0; i < n; i++) begin
            cells_due.push_back(step_cells[i]);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cell want;
        if (!i_rst_n) begin
            width_reg   = CellWidthReset;
            acc_bits    = '0;
            held_count  = '0;
            error_count = 0;
            cells_due.delete();
        end else begin
            if (i_cell.valid && i_cell.ready) begin
                if (cells_due.size() == 0) begin
                    $error("unexpected cell transaction: cell_value %04h cell_last %0b",
                           i_cell.cell_value, i_cell.cell_last);
                    error_count++;
                end else begin
                    want = cells_due.pop_front();
                    if (i_cell.cell_value !== want.value) begin
                        $error("cell_value expected %04h actual %04h",
                               want.value, i_cell.cell_value);
                        error_count++;
                    end
                    if (i_cell.cell_last !== want.last) begin
                        $error("cell_last expected %0b actual %0b",
                               want.last, i_cell.cell_last);
                        error_count++;
                    end
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                pack_byte(i_byte.data_byte, i_byte.block_end);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                width_reg = i_cfg.data;
            end
        end
        o_errors  = error_count;
        o_pending = cells_due.size();
    end

endmodule

// ===== tb/byte_to_cell_bit_packer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_to_cell_bit_packer_test
// Drives the packer with a directed set of widths and bytes (width extremes,
// clamped widths, exact fit, padding, width change mid-block and overfull
// steps), then with random blocks under random widths. Both channels idle at
// random. The checker beside the block predicts and compares every cell.
// ----------------------------------------------------------------------------
module byte_to_cell_bit_packer_test;
    import bcp_pkg::*;

    localparam int MaxGap       = 12;
    localparam int SettleCycles = 6;
    localparam int CycleLimit   = 600000;
    localparam int RandomBytes  = 440;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   byte_steady = 1'b0;
    bit   cell_steady = 1'b0;

    bcp_cfg_if  cfg_ch ();
    bcp_byte_if byte_ch ();
    bcp_cell_if cell_ch ();

    byte_to_cell_bit_packer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_byte  (byte_ch),
        .o_cell  (cell_ch)
    );

    byte_to_cell_bit_packer_checker cell_check (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg     (cfg_ch),
        .i_byte    (byte_ch),
        .i_cell    (cell_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, MaxGap);
    endfunction

    function automatic logic [ByteW-1:0] draw_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return ByteW'($urandom_range(0, 255));
    endfunction

    // mostly legal widths, now and then zero or above the clamp
    function automatic logic [CfgW-1:0] draw_width();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return CfgW'($urandom_range(17, 31));
        end else if (r == 1) begin
            return '0;
        end
        return CfgW'($urandom_range(1, 16));
    endfunction

    task automatic send_byte(input logic [ByteW-1:0] b, input logic blk_end);
        int gap;
        gap = draw_gap(byte_steady);
        @(negedge clk);
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.block_end <= blk_end;
        do @(posedge clk); while (!byte_ch.ready);
    endtask

    task automatic write_width(input logic [CfgW-1:0] w);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop sending, wait for every predicted cell, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    initial begin : cell_sink
        int gap;
        cell_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            gap = draw_gap(cell_steady);
            if (gap != 0) begin
                cell_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            cell_ch.ready <= 1'b1;
            do @(posedge clk); while (!cell_ch.valid);
        end
    end

    initial begin : stimulus
        int sent;
        int block_left;
        int phase_len;
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.block_end = 1'b0;
        sent              = 0;
        block_left        = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset width, exact fit at block end
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();
        // leftover bit padded into the last cell
        write_width(CfgW'(3));
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b1);
        settle();
        write_width(CfgW'(16));
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h81, 1'b1);
        settle();
        // zero acts as one bit per cell
        write_width(CfgW'(0));
        send_byte(8'hC3, 1'b1);
        settle();
        // above sixteen clamps to sixteen
        write_width(CfgW'(31));
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        settle();
        // hold 6 bits, then narrow the width mid-block so steps overflow
        write_width(CfgW'(13));
        send_byte(8'h96, 1'b0);
        send_byte(8'h69, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0);
        settle();
        write_width(CfgW'(1));
        send_byte(8'h5A, 1'b0);
        send_byte(8'h0F, 1'b1);
        settle();
        write_width(CfgW'(7));
        send_byte(8'h55, 1'b1);
        settle();

        // random phases; blocks run across phase boundaries on purpose
        while (sent < RandomBytes) begin
            byte_steady = ($urandom_range(0, 3) == 0);
            cell_steady = ($urandom_range(0, 3) == 0);
            write_width(draw_width());
            phase_len = $urandom_range(15, 45);
            if (phase_len > RandomBytes - sent) begin
                phase_len = RandomBytes - sent;
            end
            for (int i = 0; i < phase_len; i++) begin
                if (block_left == 0) begin
                    block_left = $urandom_range(1, 12);
                end
                block_left--;
                send_byte(draw_byte(), block_left == 0);
                sent++;
            end
            settle();
        end

        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bcp_pkg.sv
rtl/bcp_if.sv
rtl/bcp_accum.sv
rtl/bcp_out_reg.sv
rtl/byte_to_cell_bit_packer.sv
tb/byte_to_cell_bit_packer_checker.sv
tb/byte_to_cell_bit_packer_test.sv
